// ===== hw/rtl/dshs_pkg.sv =====
// Shared types, constants and phase tables for the dual stepper homing sequencer.
// Depends on nothing. Used by dual_stepper_homing_sequencer_unit.
package dshs_pkg;

  // Action codes of an input beat.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_GREEN = 2'd1;
  localparam logic [1:0] ACT_RED   = 2'd2;

  // Sensor bit masks.
  localparam logic [3:0] SNS_UH = 4'b0001;
  localparam logic [3:0] SNS_UV = 4'b0010;
  localparam logic [3:0] SNS_BV = 4'b0100;
  localparam logic [3:0] SNS_BH = 4'b1000;

  localparam logic [3:0] LED_FAULT = 4'd8;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] sensors;
    logic       red_level;
    logic [2:0] mode_switch;
  } dshs_in_t;

  typedef struct packed {
    logic [7:0] drive;
    logic [3:0] leds;
    logic [2:0] mode_state;
    logic       busy_res;
    logic       fault;
  } dshs_out_t;

  // One leg of a joint move: directions, target sensors, catch-up
  // directions and wave-drive select. Direction 1 is counter-clockwise.
  typedef struct packed {
    logic       ud;
    logic       bd;
    logic [3:0] um;
    logic [3:0] bm;
    logic       ucd;
    logic       bcd;
    logic       wave;
  } dshs_leg_t;

  function automatic dshs_leg_t leg_of(input logic [2:0] idx);
    dshs_leg_t l;
    case (idx)
      3'd0:    l = '{1'b1, 1'b0, SNS_UV, SNS_BV, 1'b1, 1'b0, 1'b0};
      3'd1:    l = '{1'b0, 1'b1, SNS_UH, SNS_BH, 1'b0, 1'b1, 1'b0};
      3'd2:    l = '{1'b1, 1'b1, SNS_UH, SNS_BV, 1'b1, 1'b1, 1'b0};
      3'd3:    l = '{1'b0, 1'b0, SNS_UV, SNS_BH, 1'b0, 1'b0, 1'b0};
      3'd4:    l = '{1'b1, 1'b0, SNS_UV, SNS_BV, 1'b1, 1'b0, 1'b1};
      3'd5:    l = '{1'b0, 1'b1, SNS_UH, SNS_BH, 1'b0, 1'b1, 1'b1};
      default: l = '{1'b1, 1'b0, SNS_UV, SNS_BH, 1'b0, 1'b0, 1'b0};
    endcase
    return l;
  endfunction

  function automatic logic [7:0] tab_uni(input logic wave, input logic [1:0] p);
    logic [7:0] v;
    case ({wave, p})
      3'b000:  v = 8'hA3;
      3'b001:  v = 8'hA6;
      3'b010:  v = 8'hAC;
      3'b011:  v = 8'hA9;
      3'b100:  v = 8'hA1;
      3'b101:  v = 8'hA2;
      3'b110:  v = 8'hA4;
      default: v = 8'hA8;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] tab_bi(input logic wave, input logic [1:0] p);
    logic [7:0] v;
    case ({wave, p})
      3'b000:  v = 8'h10;
      3'b001:  v = 8'h50;
      3'b010:  v = 8'h40;
      3'b011:  v = 8'h00;
      3'b100:  v = 8'h90;
      3'b101:  v = 8'h60;
      3'b110:  v = 8'h80;
      default: v = 8'h20;
    endcase
    return v;
  endfunction

  // Clockwise counts the phase up, counter-clockwise counts it down.
  function automatic logic [1:0] phase_next(input logic [1:0] p, input logic dir);
    return dir ? p - 2'd1 : p + 2'd1;
  endfunction

endpackage

// ===== hw/rtl/dual_stepper_homing_sequencer_unit.sv =====
// Top level of the dual stepper homing sequencer: sequencer state and result register.
// Depends on dshs_pkg.
//
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one beat per event:
// a step-period tick with the sensor bits seen in that period, a green press or
// a red press. Every accepted beat yields exactly one result beat on the output
// channel (out_valid, out_stall, out_data) that shows the coil drive byte, the
// mode LEDs, the table state, busy and fault after that event.
// The result of an accepted beat is registered and shown from the next cycle on.
// Throughput is one beat per cycle while no result stalls; the state update is a
// single table lookup and phase step done between the state registers and themselves.
// The result register doubles as the sequencer state, so a new beat is taken
// whenever the output is empty or being taken in the same cycle. While the
// receiver stalls a waiting result, in_stall is high and nothing changes.
// After reset the unipolar motor seeks its horizontal interrupter on ticks,
// then the bipolar catches up, and the block waits for a green press.
// A bad mode switch value latches the fault until the next reset.
module dual_stepper_homing_sequencer_unit
  import dshs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dshs_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output dshs_out_t out_data
);

  // Each joint-move leg owns three consecutive codes: joint stepping, bipolar
  // catch-up and unipolar catch-up.
  localparam logic [4:0] A_IDLE     = 5'd0;
  localparam logic [4:0] A_WAIT     = 5'd1;
  localparam logic [4:0] A_FAULT    = 5'd2;
  localparam logic [4:0] A_INIT_UNI = 5'd3;
  localparam logic [4:0] A_INIT_BI  = 5'd4;
  localparam logic [4:0] A_SYNC_UNI = 5'd5;
  localparam logic [4:0] A_SYNC_BI  = 5'd6;
  localparam logic [4:0] A_MOVE1    = 5'd7;
  localparam logic [4:0] A_HOME3    = 5'd8;
  localparam logic [4:0] A_HOME3_U  = 5'd10;
  localparam logic [4:0] A_SWEEP_A  = 5'd11;
  localparam logic [4:0] A_SWEEP_AU = 5'd13;
  localparam logic [4:0] A_SWEEP_B  = 5'd14;
  localparam logic [4:0] A_SWEEP_BU = 5'd16;

  logic [4:0] act_r, act_nxt;
  logic [2:0] ts_r, ts_nxt;
  logic [1:0] uph_r, uph_nxt;
  logic [1:0] bph_r, bph_nxt;
  logic [7:0] drv_r, drv_nxt;
  logic [3:0] led_r, led_nxt;
  logic [2:0] pend_r, pend_nxt;
  logic       out_valid_r;

  logic       accept;
  logic       in_leg;
  logic [4:0] leg_base;
  logic [2:0] leg_idx;
  logic [1:0] kind;
  dshs_leg_t  lg;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Which joint-move leg is running, and its first activity code.
  always_comb begin
    kind = (ts_r >= 3'd4 && ts_r <= 3'd6) ? 2'(ts_r - 3'd4) : 2'd0;
    in_leg   = 1'b1;
    leg_base = A_HOME3;
    leg_idx  = 3'd6;
    if (act_r >= A_HOME3 && act_r <= A_HOME3_U) begin
      leg_base = A_HOME3;
      leg_idx  = 3'd6;
    end else if (act_r >= A_SWEEP_A && act_r <= A_SWEEP_AU) begin
      leg_base = A_SWEEP_A;
      leg_idx  = {kind, 1'b0};
    end else if (act_r >= A_SWEEP_B && act_r <= A_SWEEP_BU) begin
      leg_base = A_SWEEP_B;
      leg_idx  = {kind, 1'b1};
    end else begin
      in_leg = 1'b0;
    end
    lg = leg_of(leg_idx);
  end

  always_comb begin
    logic [1:0] off;
    logic       uh;
    logic       bh;
    logic       leg_done;
    logic [1:0] t;
    logic [3:0] mv_mask;
    logic       mv_uni;
    logic       mv_dir;

    act_nxt  = act_r;
    ts_nxt   = ts_r;
    uph_nxt  = uph_r;
    bph_nxt  = bph_r;
    drv_nxt  = drv_r;
    led_nxt  = led_r;
    pend_nxt = pend_r;

    off      = 2'(act_r - leg_base);
    uh       = (in_data.sensors & lg.um) != 4'd0;
    bh       = (in_data.sensors & lg.bm) != 4'd0;
    leg_done = 1'b0;
    t        = ts_r[1:0];
    unique case (t)
      2'd0:    begin mv_mask = SNS_UV; mv_uni = 1'b1; mv_dir = 1'b1; end
      2'd1:    begin mv_mask = SNS_BV; mv_uni = 1'b0; mv_dir = 1'b0; end
      2'd2:    begin mv_mask = SNS_UH; mv_uni = 1'b1; mv_dir = 1'b0; end
      default: begin mv_mask = SNS_BH; mv_uni = 1'b0; mv_dir = 1'b1; end
    endcase

    if (act_r != A_FAULT) begin
      unique case (in_data.action)
        ACT_TICK: begin
          if (act_r == A_INIT_UNI || act_r == A_SYNC_UNI) begin
            if ((in_data.sensors & SNS_UH) != 4'd0) begin
              ts_nxt = 3'd3;
              if ((in_data.sensors & SNS_BH) == 4'd0) begin
                bph_nxt = phase_next(bph_r, 1'b0);
                drv_nxt = tab_bi(1'b0, bph_nxt);
                act_nxt = act_r + 5'd1;
              end else if (act_r == A_INIT_UNI) begin
                act_nxt = A_WAIT;
              end else begin
                ts_nxt  = pend_r;
                act_nxt = A_IDLE;
              end
            end else begin
              uph_nxt = phase_next(uph_r, 1'b0);
              drv_nxt = tab_uni(1'b0, uph_nxt);
            end
          end else if (act_r == A_INIT_BI || act_r == A_SYNC_BI) begin
            if ((in_data.sensors & SNS_BH) != 4'd0) begin
              if (act_r == A_INIT_BI) begin
                act_nxt = A_WAIT;
              end else begin
                ts_nxt  = pend_r;
                act_nxt = A_IDLE;
              end
            end else begin
              bph_nxt = phase_next(bph_r, 1'b0);
              drv_nxt = tab_bi(1'b0, bph_nxt);
            end
          end else if (act_r == A_MOVE1) begin
            if ((in_data.sensors & mv_mask) != 4'd0) begin
              ts_nxt  = {1'b0, t + 2'd1};
              act_nxt = A_IDLE;
            end else if (mv_uni) begin
              uph_nxt = phase_next(uph_r, mv_dir);
              drv_nxt = tab_uni(1'b0, uph_nxt);
            end else begin
              bph_nxt = phase_next(bph_r, mv_dir);
              drv_nxt = tab_bi(1'b0, bph_nxt);
            end
          end else if (in_leg) begin
            // Joint step until one motor arrives, then the other catches up.
            if (off == 2'd0) begin
              if (!uh && !bh) begin
                uph_nxt = phase_next(uph_r, lg.ud);
                bph_nxt = phase_next(bph_r, lg.bd);
                drv_nxt = (tab_uni(lg.wave, uph_nxt) & 8'h0F) |
                          (tab_bi(lg.wave, bph_nxt) & 8'hF0);
              end else if (uh && !bh) begin
                bph_nxt = phase_next(bph_r, lg.bcd);
                drv_nxt = tab_bi(lg.wave, bph_nxt);
                act_nxt = leg_base + 5'd1;
              end else if (bh && !uh) begin
                uph_nxt = phase_next(uph_r, lg.ucd);
                drv_nxt = tab_uni(lg.wave, uph_nxt);
                act_nxt = leg_base + 5'd2;
              end else begin
                leg_done = 1'b1;
              end
            end else if (off == 2'd1) begin
              if (!bh) begin
                bph_nxt = phase_next(bph_r, lg.bcd);
                drv_nxt = tab_bi(lg.wave, bph_nxt);
              end else if (!uh) begin
                uph_nxt = phase_next(uph_r, lg.ucd);
                drv_nxt = tab_uni(lg.wave, uph_nxt);
                act_nxt = leg_base + 5'd2;
              end else begin
                leg_done = 1'b1;
              end
            end else begin
              if (!uh) begin
                uph_nxt = phase_next(uph_r, lg.ucd);
                drv_nxt = tab_uni(lg.wave, uph_nxt);
              end else begin
                leg_done = 1'b1;
              end
            end

            if (leg_done) begin
              if (leg_base == A_HOME3) begin
                ts_nxt  = pend_r;
                act_nxt = A_IDLE;
              end else if (leg_base == A_SWEEP_A) begin
                act_nxt = A_SWEEP_B;
              end else begin
                // The red level only ends a sweep after a full cycle.
                act_nxt = in_data.red_level ? A_IDLE : A_SWEEP_A;
              end
            end
          end
        end
        ACT_GREEN: begin
          if (act_r == A_IDLE || act_r == A_WAIT) begin
            logic       ok;
            logic [3:0] led;
            logic [2:0] st;
            ok  = 1'b1;
            led = 4'd0;
            st  = 3'd0;
            unique case (in_data.mode_switch)
              3'd6:    begin led = 4'd1; st = 3'd0; end
              3'd5:    begin led = 4'd2; st = 3'd4; end
              3'd4:    begin led = 4'd3; st = 3'd5; end
              3'd3:    begin led = 4'd4; st = 3'd6; end
              default: ok = 1'b0;
            endcase
            if (!ok) begin
              led_nxt = LED_FAULT;
              act_nxt = A_FAULT;
            end else if (act_r == A_WAIT) begin
              led_nxt = led;
              ts_nxt  = st;
              act_nxt = A_IDLE;
            end else begin
              led_nxt  = led;
              pend_nxt = st;
              act_nxt  = (st == 3'd5) ? A_HOME3 : A_SYNC_UNI;
            end
          end
        end
        ACT_RED: begin
          if (act_r == A_IDLE) begin
            if (ts_r <= 3'd3) begin
              act_nxt = A_MOVE1;
            end else if (ts_r <= 3'd6) begin
              act_nxt = A_SWEEP_A;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= A_INIT_UNI;
      ts_r        <= 3'd0;
      uph_r       <= 2'd0;
      bph_r       <= 2'd0;
      drv_r       <= 8'd0;
      led_r       <= 4'd0;
      pend_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        act_r  <= act_nxt;
        ts_r   <= ts_nxt;
        uph_r  <= uph_nxt;
        bph_r  <= bph_nxt;
        drv_r  <= drv_nxt;
        led_r  <= led_nxt;
        pend_r <= pend_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The sequencer state itself is the result register; it only moves on an
  // accepted beat, which cannot happen while a result is stalled.
  assign out_valid           = out_valid_r;
  assign out_data.drive      = drv_r;
  assign out_data.leds       = led_r;
  assign out_data.mode_state = ts_r;
  assign out_data.busy_res   = act_r > A_FAULT;
  assign out_data.fault      = act_r == A_FAULT;

endmodule
